// ===== rtl/sfmm_pkg.sv =====
package sfmm_pkg;

	localparam int DEF_NUM_SLOTS  = 16;
	localparam int DEF_SLOT_WORDS = 64;

	localparam int MSG_WORDS_W  = 7;
	localparam int SLOT_COUNT_W = 5;
	localparam int CFG_DATA_W   = 7;
	localparam int CFG_IDX_W    = 1;

	localparam logic [MSG_WORDS_W-1:0]  MSG_WORDS_RST  = 7'd64;
	localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 5'd16;

	localparam logic [CFG_IDX_W-1:0] REG_MSG_WORDS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'd1;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_PEEK   = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] data_word;
		logic        last_word;
		logic [6:0]  read_len;
	} req_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic        has_data;
		logic [1:0]  status;
		logic        last_out;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       clr_en;
		logic       add_en;
		logic       stat_en;
		logic [1:0] stat_code;
		logic       rd_en;
		logic       rd_last;
		logic       rd_done;
	} ctl_t;

	// Status from the datapath about the read slot and the request length.
	typedef struct packed {
		logic rd_flag;
		logic len_zero;
		logic len_one;
	} sts_t;

endpackage

// ===== rtl/slot_flag_message_mailbox_unit.sv =====
// Mailbox of fixed-size message slots arranged as a ring, one writer and one reader.
// Request channel: a request (req) is taken at a rising edge where start is high and
// busy is low. An add request carries one message word; last_word closes the message.
// Remove and peek requests return the oldest unread message, read_len words at most.
// Result channel: each result sits on rsp for exactly one cycle with valid high, in the
// cycle after the request for adds and status-only answers. A read of n words gives
// its words on consecutive cycles, the first in the cycle after the request; busy stays
// high while the remaining words are read, as the message memory has a single read
// port. Adds run at one per cycle while busy is low.
// The receiver cannot stall; results must be taken as they appear.
// Configuration: cfg_we writes cfg_data to register cfg_idx (0 message length in
// words, 1 slot count). Write only while no read is in progress.
// Reset clears all flags and indices, then busy stays high while all NUM_SLOTS*SLOT_WORDS
// words of the message memory are swept to zero; configuration writes are taken during
// that sweep.
module slot_flag_message_mailbox_unit import sfmm_pkg::*; #(
	parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
	parameter int SLOT_WORDS = DEF_SLOT_WORDS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  valid,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WCNT_W = $clog2(SLOT_WORDS + 1);
	localparam int AW     = $clog2(NUM_SLOTS * SLOT_WORDS);

	ctl_t              ctl;
	sts_t              sts;
	logic [WCNT_W-1:0] n_now;
	logic [WCNT_W-1:0] word_idx;
	logic [AW-1:0]     clr_addr;

	sfmm_ctrl #(
		.NUM_SLOTS (NUM_SLOTS),
		.SLOT_WORDS(SLOT_WORDS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (req.cmd),
		.sts     (sts),
		.n_now   (n_now),
		.busy    (busy),
		.ctl     (ctl),
		.word_idx(word_idx),
		.clr_addr(clr_addr)
	);

	sfmm_dp #(
		.NUM_SLOTS (NUM_SLOTS),
		.SLOT_WORDS(SLOT_WORDS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.ctl     (ctl),
		.word_idx(word_idx),
		.clr_addr(clr_addr),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.sts     (sts),
		.n_now   (n_now),
		.valid   (valid),
		.rsp     (rsp)
	);

endmodule

// ===== rtl/sfmm_ctrl.sv =====
module sfmm_ctrl import sfmm_pkg::*; #(
	parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
	parameter int SLOT_WORDS = DEF_SLOT_WORDS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [1:0]                          cmd,
	input  sts_t                                sts,
	input  logic [$clog2(SLOT_WORDS+1)-1:0]     n_now,
	output logic                                busy,
	output ctl_t                                ctl,
	output logic [$clog2(SLOT_WORDS+1)-1:0]     word_idx,
	output logic [$clog2(NUM_SLOTS*SLOT_WORDS)-1:0] clr_addr
);

	localparam int WCNT_W = $clog2(SLOT_WORDS + 1);
	localparam int DEPTH  = NUM_SLOTS * SLOT_WORDS;
	localparam int AW     = $clog2(DEPTH);
	localparam logic [AW-1:0]     CLR_LAST = AW'(DEPTH - 1);
	localparam logic [WCNT_W-1:0] W_ONE    = WCNT_W'(1);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_READ  = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [WCNT_W-1:0] cnt_q, cnt_d;
	logic [WCNT_W-1:0] n_q, n_d;
	logic              rm_q, rm_d;
	logic [AW-1:0]     clr_q, clr_d;
	logic              accept;
	logic              is_remove;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign is_remove = (cmd == CMD_REMOVE);
	assign clr_addr  = clr_q;

	always_comb begin
		ctl       = '0;
		ctl.stat_code = STAT_OK;
		state_d   = state_q;
		cnt_d     = cnt_q;
		n_d       = n_q;
		rm_d      = rm_q;
		clr_d     = clr_q;
		word_idx  = cnt_q;
		case (state_q)
			S_CLEAR: begin
				ctl.clr_en = 1'b1;
				clr_d      = clr_q + AW'(1);
				if (clr_q == CLR_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				word_idx = '0;
				if (accept) begin
					case (cmd)
						CMD_ADD: begin
							ctl.add_en = 1'b1;
						end
						CMD_REMOVE, CMD_PEEK: begin
							if (!sts.rd_flag) begin
								ctl.stat_en   = 1'b1;
								ctl.stat_code = STAT_EMPTY;
							end else if (sts.len_zero) begin
								ctl.stat_en = 1'b1;
								ctl.rd_done = is_remove;
							end else begin
								// The first word is read in the request cycle itself.
								ctl.rd_en   = 1'b1;
								ctl.rd_last = sts.len_one;
								if (sts.len_one) begin
									ctl.rd_done = is_remove;
								end else begin
									state_d = S_READ;
									cnt_d   = W_ONE;
									n_d     = n_now;
									rm_d    = is_remove;
								end
							end
						end
						default: begin
							ctl.stat_en = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_last = ((cnt_q + W_ONE) == n_q);
				if (ctl.rd_last) begin
					ctl.rd_done = rm_q;
					state_d     = S_IDLE;
				end else begin
					cnt_d = cnt_q + W_ONE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
			n_q     <= '0;
			rm_q    <= 1'b0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			n_q     <= n_d;
			rm_q    <= rm_d;
			clr_q   <= clr_d;
		end
	end

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> (cnt_q < n_q) && (cnt_q != '0))
		else $error("read word counter out of range");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_done |=> state_q == S_IDLE)
		else $error("remove did not finish the read");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({ctl.clr_en, ctl.add_en, ctl.stat_en, ctl.rd_en}) <= 1)
		else $error("more than one datapath action in a cycle");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr_en |-> busy && !ctl.add_en)
		else $error("clearing pass while idle");

endmodule

// ===== rtl/sfmm_dp.sv =====
module sfmm_dp import sfmm_pkg::*; #(
	parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
	parameter int SLOT_WORDS = DEF_SLOT_WORDS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  req_t                                    req,
	input  ctl_t                                    ctl,
	input  logic [$clog2(SLOT_WORDS+1)-1:0]         word_idx,
	input  logic [$clog2(NUM_SLOTS*SLOT_WORDS)-1:0] clr_addr,
	input  logic                                    cfg_we,
	input  logic [CFG_IDX_W-1:0]                    cfg_idx,
	input  logic [CFG_DATA_W-1:0]                   cfg_data,
	output sts_t                                    sts,
	output logic [$clog2(SLOT_WORDS+1)-1:0]         n_now,
	output logic                                    valid,
	output rsp_t                                    rsp
);

	localparam int WCNT_W = $clog2(SLOT_WORDS + 1);
	localparam int DEPTH  = NUM_SLOTS * SLOT_WORDS;
	localparam int AW     = $clog2(DEPTH);
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CMP_W  = (SLOT_W + 1 > SLOT_COUNT_W) ? SLOT_W + 1 : SLOT_COUNT_W;
	localparam logic [AW-1:0]          SW_A     = AW'(SLOT_WORDS);
	localparam logic [MSG_WORDS_W-1:0] SW_M     = MSG_WORDS_W'(SLOT_WORDS);
	localparam logic [CMP_W-1:0]       NS_C     = CMP_W'(NUM_SLOTS);
	localparam logic [SLOT_W:0]        S_ONE    = (SLOT_W + 1)'(1);
	localparam logic [WCNT_W-1:0]      W_ONE    = WCNT_W'(1);

	logic [31:0]             mem [DEPTH];
	logic [31:0]             mem_q;
	logic [NUM_SLOTS-1:0]    flag_q;
	logic [SLOT_W-1:0]       wi_q, ri_q;
	logic [WCNT_W-1:0]       add_cnt_q;
	logic                    add_active_q, add_refused_q;
	logic [MSG_WORDS_W-1:0]  msg_words_q;
	logic [SLOT_COUNT_W-1:0] slot_count_q;

	logic                    valid_s1, has_s1, last_s1;
	logic [1:0]              status_s1;

	logic [MSG_WORDS_W-1:0]  eff_words_m;
	logic [WCNT_W-1:0]       eff_words;
	logic [CMP_W-1:0]        sc_ext, eff_slots;
	logic [SLOT_W:0]         wi_inc, ri_inc;
	logic [SLOT_W-1:0]       wi_next, ri_next;
	logic                    cur_refused, store;
	logic [WCNT_W-1:0]       cur_cnt;
	logic [AW-1:0]           add_addr, rd_addr, wr_addr;

	// Configuration values outside their range are saturated.
	assign eff_words_m = (msg_words_q == '0) ? MSG_WORDS_W'(1) :
	                     (msg_words_q > SW_M) ? SW_M : msg_words_q;
	assign eff_words   = WCNT_W'(eff_words_m);
	assign sc_ext      = CMP_W'(slot_count_q);
	assign eff_slots   = (sc_ext == '0) ? CMP_W'(1) : (sc_ext > NS_C) ? NS_C : sc_ext;

	assign wi_inc  = {1'b0, wi_q} + S_ONE;
	assign ri_inc  = {1'b0, ri_q} + S_ONE;
	assign wi_next = (CMP_W'(wi_inc) >= eff_slots) ? '0 : wi_inc[SLOT_W-1:0];
	assign ri_next = (CMP_W'(ri_inc) >= eff_slots) ? '0 : ri_inc[SLOT_W-1:0];

	assign n_now = (req.read_len < eff_words_m) ? WCNT_W'(req.read_len) : eff_words;
	assign sts.rd_flag  = flag_q[ri_q];
	assign sts.len_zero = (n_now == '0);
	assign sts.len_one  = (n_now == W_ONE);

	// The first word of a message decides whether the whole message is refused.
	assign cur_refused = add_active_q ? add_refused_q : flag_q[wi_q];
	assign cur_cnt     = add_active_q ? add_cnt_q : '0;
	assign store       = ctl.add_en && !cur_refused && (cur_cnt < eff_words);

	assign add_addr = AW'(wi_q) * SW_A + AW'(cur_cnt);
	assign rd_addr  = AW'(ri_q) * SW_A + AW'(word_idx);
	assign wr_addr  = ctl.clr_en ? clr_addr : add_addr;

	always_ff @(posedge clk) begin
		if (ctl.clr_en || store) begin
			mem[wr_addr] <= ctl.clr_en ? 32'd0 : req.data_word;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q        <= '0;
			wi_q          <= '0;
			ri_q          <= '0;
			add_cnt_q     <= '0;
			add_active_q  <= 1'b0;
			add_refused_q <= 1'b0;
			msg_words_q   <= MSG_WORDS_RST;
			slot_count_q  <= SLOT_COUNT_RST;
			valid_s1      <= 1'b0;
		end else begin
			valid_s1 <= ctl.add_en || ctl.stat_en || ctl.rd_en;
			if (cfg_we && cfg_idx == REG_MSG_WORDS) begin
				msg_words_q <= cfg_data;
			end
			if (cfg_we && cfg_idx == REG_SLOT_COUNT) begin
				slot_count_q <= cfg_data[SLOT_COUNT_W-1:0];
			end
			if (ctl.add_en) begin
				if (req.last_word) begin
					add_active_q  <= 1'b0;
					add_refused_q <= 1'b0;
					add_cnt_q     <= '0;
					if (!cur_refused) begin
						flag_q[wi_q] <= 1'b1;
						wi_q         <= wi_next;
					end
				end else begin
					add_active_q  <= 1'b1;
					add_refused_q <= cur_refused;
					add_cnt_q     <= store ? cur_cnt + W_ONE : cur_cnt;
				end
			end
			if (ctl.rd_done) begin
				flag_q[ri_q] <= 1'b0;
				ri_q         <= ri_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		has_s1  <= ctl.rd_en;
		last_s1 <= ctl.rd_en ? ctl.rd_last : 1'b1;
		if (ctl.add_en) begin
			status_s1 <= cur_refused ? STAT_FULL : STAT_OK;
		end else if (ctl.rd_en) begin
			status_s1 <= STAT_OK;
		end else begin
			status_s1 <= ctl.stat_code;
		end
	end

	assign valid        = valid_s1;
	assign rsp.out_word = has_s1 ? mem_q : 32'd0;
	assign rsp.has_data = has_s1;
	assign rsp.status   = status_s1;
	assign rsp.last_out = last_s1;

	a_refused_in_add: assert property (@(posedge clk) disable iff (!arst_n)
		add_refused_q |-> add_active_q)
		else $error("refused mark outside a message");

	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid && rsp.has_data |-> rsp.status == STAT_OK)
		else $error("data word with a failure status");

	a_refused_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.add_en && add_active_q && add_refused_q |-> !store)
		else $error("word stored for a refused message");

endmodule
